@@ src/fbpa_pkg.sv @@
`timescale 1ns / 1ps

package fbpa_pkg;

  localparam int AddrW   = 32;
  localparam int SizeW   = 32;
  localparam int BsizeW  = 16;
  localparam int StatusW = 3;
  localparam int IdxW    = 8;
  localparam int StrideW = BsizeW + 1;

  // shift-add steps for index times stride, one quotient bit per divide step
  localparam int MulSteps = IdxW;
  localparam int DivSteps = AddrW;

  localparam logic [AddrW-1:0]  BaseReset  = 32'd0;
  localparam logic [BsizeW-1:0] BsizeReset = 16'd128;

  localparam logic CFG_BASE_ADDRESS = 1'b0;
  localparam logic CFG_BLOCK_SIZE   = 1'b1;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 3'd0,
    ST_ZERO_SIZE  = 3'd1,
    ST_TOO_BIG    = 3'd2,
    ST_POOL_EMPTY = 3'd3,
    ST_BAD_INDEX  = 3'd4,
    ST_FULL_NULL  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_DIV,
    S_DONE
  } state_e;

endpackage

@@ src/fbpa_ram.sv @@
`timescale 1ns / 1ps

module fbpa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/fixed_block_pool_allocator.sv @@
`timescale 1ns / 1ps

// channel  direction  handshake                  payload
// in       to block   in_valid_i / in_stall_o    action_i, request_size_i, block_address_i
// out      from block out_valid_o / out_stall_i  granted_address_o, status_o
// cfg      to block   cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// zero size, too big, empty, null or full free: straight to result; bad index after the read
// an allocate: stack read, 8 shift-add steps of index times stride, result
// a free: one quotient bit per cycle of the 32-bit divide, then result
// asynchronous active-low reset; the stack then reads as entry i holding i, no clearing pass
// a new transfer is taken once the previous item has moved to the output register,
// even while out_stall_i holds that result

module fixed_block_pool_allocator #(
  parameter int BLOCKS   = 16,
  parameter int RED_ZONE = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [fbpa_pkg::AddrW-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [fbpa_pkg::SizeW-1:0]     request_size_i,
  input  logic [fbpa_pkg::AddrW-1:0]     block_address_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [fbpa_pkg::AddrW-1:0]     granted_address_o,
  output logic [fbpa_pkg::StatusW-1:0]   status_o
);

  localparam int AW   = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int CW   = $clog2(BLOCKS + 1);
  localparam int IW   = fbpa_pkg::IdxW;
  localparam int SW   = fbpa_pkg::StrideW;
  localparam int PW   = IW + SW;
  localparam int DW   = fbpa_pkg::AddrW;
  localparam int CntW = $clog2(fbpa_pkg::DivSteps);

  fbpa_pkg::state_e  state_q, state_d;
  fbpa_pkg::status_e status_q, status_d;
  fbpa_pkg::status_e out_status_q, out_status_d;

  logic [DW-1:0]               base_q, base_d;
  logic [fbpa_pkg::BsizeW-1:0] bsize_q, bsize_d;
  logic [CW-1:0]               count_q, count_d;
  logic [BLOCKS-1:0]           vld_q, vld_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [DW-1:0]               quo_q, quo_d;
  logic [SW-1:0]               rem_q, rem_d;
  logic [IW-1:0]               mpl_q, mpl_d;
  logic [PW-1:0]               mcd_q, mcd_d;
  logic [PW-1:0]               acc_q, acc_d;
  logic                        grant_q, grant_d;
  logic [AW-1:0]               rd_addr_q, rd_addr_d;
  logic                        out_valid_q, out_valid_d;
  logic [DW-1:0]               out_addr_q, out_addr_d;

  logic [SW-1:0] stride;
  logic [SW:0]   trial;
  logic [SW:0]   diff;
  logic          q_bit;
  logic [IW-1:0] rd_idx;
  logic          in_xfer;
  logic          out_load;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [IW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [IW-1:0] ram_rdata;

  fbpa_ram #(
    .Width (IW),
    .Depth (BLOCKS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign stride = SW'(bsize_q) + SW'(RED_ZONE);

  // restoring divide step; a zero stride yields all-ones quotient bits
  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, stride};
  assign q_bit = (trial >= {1'b0, stride});

  // an entry never written since reset holds its own index
  assign rd_idx = vld_q[rd_addr_q] ? ram_rdata : IW'(rd_addr_q);

  assign in_stall_o = (state_q != fbpa_pkg::S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_load   = !out_valid_q || !out_stall_i;
  assign ram_raddr  = AW'(count_q - CW'(1));

  always_comb begin
    base_d  = base_q;
    bsize_d = bsize_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fbpa_pkg::CFG_BASE_ADDRESS: base_d  = cfg_wdata_i;
        fbpa_pkg::CFG_BLOCK_SIZE:   bsize_d = cfg_wdata_i[fbpa_pkg::BsizeW-1:0];
        default:                    base_d  = base_q;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    status_d     = status_q;
    count_d      = count_q;
    vld_d        = vld_q;
    cnt_d        = cnt_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    mpl_d        = mpl_q;
    mcd_d        = mcd_q;
    acc_d        = acc_q;
    grant_d      = grant_q;
    rd_addr_d    = rd_addr_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_waddr    = count_q[AW-1:0];
    ram_wdata    = {quo_q[IW-2:0], q_bit};

    unique case (state_q)
      fbpa_pkg::S_IDLE: begin
        if (in_xfer) begin
          grant_d = 1'b0;
          state_d = fbpa_pkg::S_DONE;
          if (action_i == fbpa_pkg::ACT_ALLOC) begin
            priority if (request_size_i == '0) begin
              status_d = fbpa_pkg::ST_ZERO_SIZE;
            end else if (request_size_i > fbpa_pkg::SizeW'(bsize_q)) begin
              status_d = fbpa_pkg::ST_TOO_BIG;
            end else if (count_q == '0) begin
              status_d = fbpa_pkg::ST_POOL_EMPTY;
            end else begin
              count_d   = count_q - CW'(1);
              rd_addr_d = ram_raddr;
              state_d   = fbpa_pkg::S_READ;
            end
          end else begin
            priority if (block_address_i == '0) begin
              status_d = fbpa_pkg::ST_FULL_NULL;
            end else if (count_q == CW'(BLOCKS)) begin
              status_d = fbpa_pkg::ST_FULL_NULL;
            end else begin
              quo_d   = block_address_i - base_q;
              rem_d   = '0;
              cnt_d   = '0;
              state_d = fbpa_pkg::S_DIV;
            end
          end
        end
      end

      fbpa_pkg::S_READ: begin
        if ({1'b0, rd_idx} >= (IW + 1)'(BLOCKS)) begin
          status_d = fbpa_pkg::ST_BAD_INDEX;
          state_d  = fbpa_pkg::S_DONE;
        end else begin
          mpl_d   = rd_idx;
          mcd_d   = PW'(stride);
          acc_d   = '0;
          cnt_d   = '0;
          state_d = fbpa_pkg::S_MUL;
        end
      end

      fbpa_pkg::S_MUL: begin
        acc_d = acc_q + (mpl_q[0] ? mcd_q : '0);
        mpl_d = mpl_q >> 1;
        mcd_d = mcd_q << 1;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(fbpa_pkg::MulSteps - 1)) begin
          grant_d  = 1'b1;
          status_d = fbpa_pkg::ST_OK;
          state_d  = fbpa_pkg::S_DONE;
        end
      end

      fbpa_pkg::S_DIV: begin
        rem_d = q_bit ? diff[SW-1:0] : trial[SW-1:0];
        quo_d = {quo_q[DW-2:0], q_bit};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(fbpa_pkg::DivSteps - 1)) begin
          // push the low quotient bits onto the stack
          ram_we                      = 1'b1;
          vld_d[count_q[AW-1:0]]      = 1'b1;
          count_d                     = count_q + CW'(1);
          status_d                    = fbpa_pkg::ST_OK;
          state_d                     = fbpa_pkg::S_DONE;
        end
      end

      fbpa_pkg::S_DONE: begin
        if (out_load) begin
          out_valid_d  = 1'b1;
          out_addr_d   = grant_q ? (base_q + DW'(acc_q)) : '0;
          out_status_d = status_q;
          state_d      = fbpa_pkg::S_IDLE;
        end
      end

      default: state_d = fbpa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fbpa_pkg::S_IDLE;
      base_q      <= fbpa_pkg::BaseReset;
      bsize_q     <= fbpa_pkg::BsizeReset;
      count_q     <= CW'(BLOCKS);
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      bsize_q     <= bsize_d;
      count_q     <= count_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    cnt_q        <= cnt_d;
    quo_q        <= quo_d;
    rem_q        <= rem_d;
    mpl_q        <= mpl_d;
    mcd_q        <= mcd_d;
    acc_q        <= acc_d;
    grant_q      <= grant_d;
    rd_addr_q    <= rd_addr_d;
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o       = out_valid_q;
  assign granted_address_o = out_addr_q;
  assign status_o          = out_status_q;

endmodule

@@ test/tb_fixed_block_pool_allocator.sv @@
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator;

  localparam int POOL_BLOCKS    = 16;
  localparam int GUARD_BYTES    = 32;
  localparam int OUT_HOLD       = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_ITEMS    = 340;

  typedef struct packed {
    logic [fbpa_pkg::AddrW-1:0] addr;
    fbpa_pkg::status_e          status;
  } grant_t;

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         cfg_we_i        = 1'b0;
  logic                         cfg_idx_i       = fbpa_pkg::CFG_BASE_ADDRESS;
  logic [fbpa_pkg::AddrW-1:0]   cfg_wdata_i     = '0;
  logic                         in_valid_i      = 1'b0;
  logic                         in_stall_o;
  logic                         action_i        = fbpa_pkg::ACT_ALLOC;
  logic [fbpa_pkg::SizeW-1:0]   request_size_i  = '0;
  logic [fbpa_pkg::AddrW-1:0]   block_address_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i     = 1'b0;
  logic [fbpa_pkg::AddrW-1:0]   granted_address_o;
  logic [fbpa_pkg::StatusW-1:0] status_o;

  // predictor copy of the pool
  logic [fbpa_pkg::AddrW-1:0]  pool_base;
  logic [fbpa_pkg::BsizeW-1:0] pool_bsize;
  logic [fbpa_pkg::IdxW-1:0]   free_stack [POOL_BLOCKS];
  int                          free_top;

  grant_t      expected_grants[$];
  int unsigned mismatch_count  = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned recv_stall_left = 0;
  logic        hold_request    = 1'b0;
  logic        calm_in         = 1'b0;
  logic        calm_out        = 1'b0;

  fixed_block_pool_allocator #(
    .BLOCKS   (POOL_BLOCKS),
    .RED_ZONE (GUARD_BYTES)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .request_size_i    (request_size_i),
    .block_address_i   (block_address_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .granted_address_o (granted_address_o),
    .status_o          (status_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(20, 80);
  endfunction

  function automatic grant_t model_pool_op(logic act, logic [fbpa_pkg::SizeW-1:0] size,
                                           logic [fbpa_pkg::AddrW-1:0] addr);
    grant_t      g;
    logic [31:0] stride;
    logic [31:0] quot;
    g.addr   = '0;
    g.status = fbpa_pkg::ST_OK;
    stride   = 32'(pool_bsize) + GUARD_BYTES;
    if (act == fbpa_pkg::ACT_ALLOC) begin
      if (size == '0) begin
        g.status = fbpa_pkg::ST_ZERO_SIZE;
      end else if (size > 32'(pool_bsize)) begin
        g.status = fbpa_pkg::ST_TOO_BIG;
      end else if (free_top == 0) begin
        g.status = fbpa_pkg::ST_POOL_EMPTY;
      end else begin
        free_top--;
        // a popped index that is out of range is still consumed
        if (free_stack[free_top] >= POOL_BLOCKS) g.status = fbpa_pkg::ST_BAD_INDEX;
        else g.addr = pool_base + 32'(free_stack[free_top]) * stride;
      end
    end else if (addr == '0 || free_top >= POOL_BLOCKS) begin
      g.status = fbpa_pkg::ST_FULL_NULL;
    end else begin
      quot = (stride == '0) ? '1 : (addr - pool_base) / stride;
      free_stack[free_top] = quot[fbpa_pkg::IdxW-1:0];
      free_top++;
    end
    return g;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < 100)
      $display("mismatch %s at %0t: got %h want %h", what, $time, got, want);
    mismatch_count++;
  endtask

  task automatic send_pool_op(logic act, logic [fbpa_pkg::SizeW-1:0] size,
                              logic [fbpa_pkg::AddrW-1:0] addr);
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    action_i        <= act;
    request_size_i  <= size;
    block_address_i <= addr;
    do @(posedge clk_i); while (in_stall_o);
    expected_grants.push_back(model_pool_op(act, size, addr));
  endtask

  task automatic write_pool_reg(logic idx, logic [fbpa_pkg::AddrW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == fbpa_pkg::CFG_BASE_ADDRESS) pool_base = data;
    else pool_bsize = data[fbpa_pkg::BsizeW-1:0];
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_random_op(int unsigned alloc_pct);
    int unsigned                pick;
    int unsigned                gap;
    logic [31:0]                stride;
    logic [fbpa_pkg::SizeW-1:0] size;
    logic [fbpa_pkg::AddrW-1:0] addr;
    stride = 32'(pool_bsize) + GUARD_BYTES;
    pick   = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < alloc_pct) begin
      if (pick < 70) size = $urandom_range(1, pool_bsize);
      else if (pick < 78) size = '0;
      else if (pick < 82) size = 32'(pool_bsize);
      else if (pick < 86) size = 32'(pool_bsize) + 1;
      else size = $urandom;
      send_pool_op(fbpa_pkg::ACT_ALLOC, size, $urandom);
    end else begin
      // mostly addresses inside the pool's blocks, at any offset within the stride
      if (pick < 72)
        addr = pool_base + $urandom_range(0, POOL_BLOCKS - 1) * stride
               + $urandom_range(0, stride - 1);
      else if (pick < 80) addr = '0;
      else if (pick < 90) addr = pool_base + $urandom_range(POOL_BLOCKS, 300) * stride;
      else addr = $urandom;
      send_pool_op(fbpa_pkg::ACT_FREE, $urandom, addr);
    end
    if (!calm_in) begin
      gap = idle_len();
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic test_directed_cases();
    send_pool_op(fbpa_pkg::ACT_ALLOC, '0, $urandom);
    send_pool_op(fbpa_pkg::ACT_ALLOC, '1, $urandom);
    send_pool_op(fbpa_pkg::ACT_ALLOC, 129, $urandom);
    send_pool_op(fbpa_pkg::ACT_ALLOC, 128, $urandom);
    send_pool_op(fbpa_pkg::ACT_FREE, $urandom, '0);
    send_pool_op(fbpa_pkg::ACT_FREE, $urandom, 15 * 160 + 159);
    send_pool_op(fbpa_pkg::ACT_FREE, $urandom, 160);
    // drain the pool; the last grant is block 0 at address 0
    repeat (POOL_BLOCKS) send_pool_op(fbpa_pkg::ACT_ALLOC, 1, $urandom);
    send_pool_op(fbpa_pkg::ACT_ALLOC, 64, $urandom);
    send_pool_op(fbpa_pkg::ACT_FREE, $urandom, '0);
    // index from the top address is far out of range, then popped
    send_pool_op(fbpa_pkg::ACT_FREE, $urandom, '1);
    send_pool_op(fbpa_pkg::ACT_ALLOC, 1, $urandom);
  endtask

  task automatic test_config_extremes();
    logic [31:0] stride;
    settle();
    write_pool_reg(fbpa_pkg::CFG_BASE_ADDRESS, '1);
    write_pool_reg(fbpa_pkg::CFG_BLOCK_SIZE, {16'h5a5a, 16'hffff});
    stride = 32'(pool_bsize) + GUARD_BYTES;
    send_pool_op(fbpa_pkg::ACT_FREE, $urandom, pool_base + 2 * stride);
    send_pool_op(fbpa_pkg::ACT_FREE, $urandom, pool_base);
    send_pool_op(fbpa_pkg::ACT_ALLOC, 65535, $urandom);
    send_pool_op(fbpa_pkg::ACT_ALLOC, 65536, $urandom);
    send_pool_op(fbpa_pkg::ACT_ALLOC, 1, $urandom);
    settle();
    write_pool_reg(fbpa_pkg::CFG_BASE_ADDRESS, '0);
    write_pool_reg(fbpa_pkg::CFG_BLOCK_SIZE, {16'ha5a5, 16'h0001});
    send_pool_op(fbpa_pkg::ACT_FREE, $urandom, 33 * 5);
    send_pool_op(fbpa_pkg::ACT_ALLOC, 2, $urandom);
    send_pool_op(fbpa_pkg::ACT_ALLOC, 1, $urandom);
  endtask

  task automatic test_output_hold();
    calm_in      = 1'b1;
    hold_request = 1'b1;
    // sender keeps offering while the held output backs up into in_stall_o
    repeat (8) begin
      send_pool_op(fbpa_pkg::ACT_ALLOC, 1, $urandom);
      send_pool_op(fbpa_pkg::ACT_FREE, $urandom,
                   pool_base + 33 * $urandom_range(0, POOL_BLOCKS - 1));
    end
    calm_in = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [fbpa_pkg::AddrW-1:0]  base;
    logic [fbpa_pkg::BsizeW-1:0] bsize;
    int unsigned                 alloc_pct;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case ($urandom_range(0, 3))
        0:       base = '0;
        1:       base = '1 - $urandom_range(0, 4095);
        default: base = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0:       bsize = 16'd1;
        1:       bsize = 16'hffff;
        2, 3:    bsize = 16'($urandom_range(1, 65535));
        default: bsize = 16'($urandom_range(1, 256));
      endcase
      write_pool_reg(fbpa_pkg::CFG_BASE_ADDRESS, base);
      write_pool_reg(fbpa_pkg::CFG_BLOCK_SIZE, {16'($urandom), bsize});
      alloc_pct = $urandom_range(25, 75);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 64 == 0) begin
          calm_in  = ($urandom_range(0, 3) == 0);
          calm_out = ($urandom_range(0, 3) == 0);
        end
        send_random_op(alloc_pct);
      end
    end
    calm_in  = 1'b0;
    calm_out = 1'b0;
  endtask

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_request    = 1'b0;
      recv_stall_left = OUT_HOLD;
      out_stall_i <= 1'b1;
    end else if (recv_stall_left != 0) begin
      recv_stall_left--;
      out_stall_i <= 1'b1;
    end else if (calm_out || $urandom_range(0, 99) < 75) begin
      out_stall_i <= 1'b0;
    end else begin
      recv_stall_left = idle_len();
      out_stall_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    grant_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_grants.size() == 0) begin
        report_mismatch("result with none pending", granted_address_o, '0);
      end else begin
        want = expected_grants.pop_front();
        if (granted_address_o !== want.addr)
          report_mismatch("granted_address", granted_address_o, want.addr);
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
      end
    end
  end

  // no transfer on either side for too long means the block is stuck
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL fixed_block_pool_allocator");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    pool_base  = fbpa_pkg::BaseReset;
    pool_bsize = fbpa_pkg::BsizeReset;
    for (int i = 0; i < POOL_BLOCKS; i++) free_stack[i] = fbpa_pkg::IdxW'(i);
    free_top = POOL_BLOCKS;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_config_extremes();
    test_output_hold();
    test_random_traffic();
    settle();

    if (mismatch_count == 0) begin
      $display("PASS fixed_block_pool_allocator");
    end else begin
      $display("FAIL fixed_block_pool_allocator");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/fbpa_pkg.sv
src/fbpa_ram.sv
src/fixed_block_pool_allocator.sv
test/tb_fixed_block_pool_allocator.sv
